// ----- hdl/nls_pkg.sv -----
// Package for the number literal scanner: item types, scan state, character helpers.
`timescale 1ns / 1ps

package nls_pkg;

    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_PREFIX  = 10'b00_0000_0010,
        PH_INT     = 10'b00_0000_0100,
        PH_FRAC    = 10'b00_0000_1000,
        PH_EXPSIGN = 10'b00_0001_0000,
        PH_EXPDIG  = 10'b00_0010_0000,
        PH_FSUF    = 10'b00_0100_0000,
        PH_ISUF    = 10'b00_1000_0000,
        PH_SUFLAST = 10'b01_0000_0000,
        PH_END     = 10'b10_0000_0000
    } t_phase;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2,
        RADIX_OCT = 2'd3
    } t_radix;

    typedef struct packed {
        logic [7:0] text_byte;
        logic [7:0] next_byte;
        logic       token_start;
    } t_scan_in;

    typedef struct packed {
        logic consumed;
        logic literal_done;
        logic malformed;
    } t_scan_out;

    typedef struct packed {
        t_phase phase;
        t_radix radix;
        logic   error_seen;
        logic   digit_seen;
    } t_scan_state;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic in_radix(input logic [7:0] c, input t_radix r);
        logic res;
        case (r)
            RADIX_HEX: res = is_dec(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
            RADIX_BIN: res = (c == CH_0) || (c == CH_1);
            RADIX_OCT: res = (c >= CH_0) && (c <= CH_7);
            default:   res = is_dec(c);
        endcase
        return res;
    endfunction

    function automatic logic word_start(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || (c == CH_UNDER) || (c == CH_DOLLAR);
    endfunction

endpackage

// ----- hdl/nls_step.sv -----
// Per-byte scan step: next scan state and result item from the current state and byte.
`timescale 1ns / 1ps

module nls_step (
    input  nls_pkg::t_scan_state i_state,
    input  nls_pkg::t_scan_in    i_item,
    output nls_pkg::t_scan_state o_state,
    output nls_pkg::t_scan_out   o_item
);

    logic [7:0]           c;
    logic [7:0]           nb;
    logic                 non_dec;
    logic                 err_run;
    logic                 take;
    logic                 idle_path;
    nls_pkg::t_scan_state ns;

    assign c       = i_item.text_byte;
    assign nb      = i_item.next_byte;
    assign non_dec = (i_state.radix != nls_pkg::RADIX_DEC);
    // error flag once a digit run ends, empty runs are errors
    assign err_run = i_state.error_seen | ~i_state.digit_seen;

    always_comb begin
        ns        = i_state;
        take      = 1'b0;
        idle_path = 1'b0;
        case (i_state.phase)
            nls_pkg::PH_PREFIX: begin
                if (c == nls_pkg::CH_NUL) begin
                    ns.error_seen = 1'b1;
                end else begin
                    ns.phase = nls_pkg::PH_INT;
                    take     = 1'b1;
                end
            end
            nls_pkg::PH_INT: begin
                if (nls_pkg::in_radix(c, i_state.radix) || c == nls_pkg::CH_UNDER) begin
                    ns.digit_seen = 1'b1;
                    take          = 1'b1;
                end else begin
                    ns.error_seen = err_run;
                    if (c == nls_pkg::CH_U || c == nls_pkg::CH_I) begin
                        ns.phase = nls_pkg::PH_ISUF;
                        take     = 1'b1;
                    end else if (!err_run) begin
                        if (c == nls_pkg::CH_DOT
                            && !(nls_pkg::word_start(nb) || nb == nls_pkg::CH_DOT)) begin
                            ns.error_seen = non_dec;
                            ns.phase      = nls_pkg::PH_FRAC;
                            take          = 1'b1;
                        end else if (c == nls_pkg::CH_E_LO || c == nls_pkg::CH_E_UP) begin
                            ns.error_seen = non_dec;
                            ns.digit_seen = 1'b0;
                            ns.phase      = nls_pkg::PH_EXPSIGN;
                            take          = 1'b1;
                        end else if (c == nls_pkg::CH_F) begin
                            ns.error_seen = non_dec;
                            ns.phase      = nls_pkg::PH_FSUF;
                            take          = 1'b1;
                        end
                    end
                end
            end
            nls_pkg::PH_FRAC: begin
                if (nls_pkg::is_dec(c) || c == nls_pkg::CH_UNDER) begin
                    take = 1'b1;
                end else if (c == nls_pkg::CH_E_LO || c == nls_pkg::CH_E_UP) begin
                    ns.error_seen = i_state.error_seen | non_dec;
                    ns.digit_seen = 1'b0;
                    ns.phase      = nls_pkg::PH_EXPSIGN;
                    take          = 1'b1;
                end else if (c == nls_pkg::CH_F) begin
                    ns.error_seen = i_state.error_seen | non_dec;
                    ns.phase      = nls_pkg::PH_FSUF;
                    take          = 1'b1;
                end
            end
            nls_pkg::PH_EXPSIGN, nls_pkg::PH_EXPDIG: begin
                if (i_state.phase == nls_pkg::PH_EXPSIGN
                    && (c == nls_pkg::CH_PLUS || c == nls_pkg::CH_MINUS)) begin
                    ns.phase = nls_pkg::PH_EXPDIG;
                    take     = 1'b1;
                end else if (nls_pkg::is_dec(c) || c == nls_pkg::CH_UNDER) begin
                    ns.digit_seen = 1'b1;
                    ns.phase      = nls_pkg::PH_EXPDIG;
                    take          = 1'b1;
                end else begin
                    ns.error_seen = err_run;
                    if (c == nls_pkg::CH_F) begin
                        ns.error_seen = err_run | non_dec;
                        ns.phase      = nls_pkg::PH_FSUF;
                        take          = 1'b1;
                    end
                end
            end
            nls_pkg::PH_FSUF: begin
                if ((c == nls_pkg::CH_3 && nb == nls_pkg::CH_2)
                    || (c == nls_pkg::CH_6 && nb == nls_pkg::CH_4)) begin
                    ns.phase = nls_pkg::PH_SUFLAST;
                    take     = 1'b1;
                end else begin
                    ns.error_seen = 1'b1;
                end
            end
            nls_pkg::PH_ISUF: begin
                if (c == nls_pkg::CH_8 || c == nls_pkg::CH_S) begin
                    ns.phase = nls_pkg::PH_END;
                    take     = 1'b1;
                end else if ((c == nls_pkg::CH_1 && nb == nls_pkg::CH_6)
                    || (c == nls_pkg::CH_3 && nb == nls_pkg::CH_2)
                    || (c == nls_pkg::CH_6 && nb == nls_pkg::CH_4)) begin
                    ns.phase = nls_pkg::PH_SUFLAST;
                    take     = 1'b1;
                end else begin
                    ns.error_seen = 1'b1;
                end
            end
            nls_pkg::PH_SUFLAST: begin
                if (c == nls_pkg::CH_NUL) begin
                    ns.error_seen = 1'b1;
                end else begin
                    ns.phase = nls_pkg::PH_END;
                    take     = 1'b1;
                end
            end
            nls_pkg::PH_END: begin
                take = 1'b0;
            end
            default: begin
                idle_path = 1'b1;
                ns.phase  = nls_pkg::PH_IDLE;
                if (i_item.token_start && nls_pkg::is_dec(c)) begin
                    take          = 1'b1;
                    ns.error_seen = 1'b0;
                    if (c == nls_pkg::CH_0
                        && (nb == nls_pkg::CH_X || nb == nls_pkg::CH_B
                            || nb == nls_pkg::CH_O)) begin
                        ns.radix      = (nb == nls_pkg::CH_X) ? nls_pkg::RADIX_HEX :
                                        (nb == nls_pkg::CH_B) ? nls_pkg::RADIX_BIN :
                                                                nls_pkg::RADIX_OCT;
                        ns.digit_seen = 1'b0;
                        ns.phase      = nls_pkg::PH_PREFIX;
                    end else begin
                        ns.radix      = nls_pkg::RADIX_DEC;
                        ns.digit_seen = 1'b1;
                        ns.phase      = nls_pkg::PH_INT;
                    end
                end
            end
        endcase

        o_item.consumed     = take;
        o_item.literal_done = ~idle_path & ~take;
        o_item.malformed    = ~idle_path & ~take & ns.error_seen;
        if (!idle_path && !take) begin
            ns.phase = nls_pkg::PH_IDLE;
        end
        o_state = ns;
    end

endmodule

// ----- hdl/number_literal_scanner.sv -----
// Top level of the number literal scanner: input register, scan state, result register.
// An accepted byte is held in the input register; its result item is then registered in the result register.
// Throughput: one byte per cycle when the output is not stalled; the scan state updates as an
// item moves from the input register into the result register, so bytes follow back to back.
// Reset: synchronous active-low i_rst_n empties both registers and returns the scan
// state to idle, decimal radix, no error, no digit.
`timescale 1ns / 1ps

module number_literal_scanner (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  nls_pkg::t_scan_in   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output nls_pkg::t_scan_out  o_out_item
);

    logic                 r_in_valid;
    nls_pkg::t_scan_in    r_in_item;
    logic                 r_out_valid;
    nls_pkg::t_scan_out   r_out_item;
    nls_pkg::t_scan_state r_state;
    nls_pkg::t_scan_state n_state;
    nls_pkg::t_scan_out   n_out_item;
    logic                 move;

    nls_step u_step (
        .i_state (r_state),
        .i_item  (r_in_item),
        .o_state (n_state),
        .o_item  (n_out_item)
    );

    assign move       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{phase: nls_pkg::PH_IDLE, radix: nls_pkg::RADIX_DEC,
                             error_seen: 1'b0, digit_seen: 1'b0};
        end else begin
            if (move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_done_not_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.literal_done && o_out_item.consumed))
        else $error("literal end byte reported as consumed");

    a_malformed_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.malformed) |-> o_out_item.literal_done)
        else $error("malformed flag without literal end");

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && n_out_item.literal_done) |=> (r_state.phase == nls_pkg::PH_IDLE))
        else $error("scan state not idle after literal end");

    a_stall_only_when_full: assert property (@(posedge i_clk)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_valid))
        else $error("registers hold items after reset");

endmodule
